// File: sv/amr_pkg.sv
`default_nettype none

package amr_pkg;

   localparam int WORD_BITS        = 32;
   localparam int STATUS_BITS      = 3;
   localparam int SLOT_FIELD_BITS  = 3;

   localparam int NUM_REGIONS_DEFAULT  = 8;
   localparam int ADDRESS_BITS_DEFAULT = 32;

   localparam logic [STATUS_BITS-1:0] ST_OK      = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_ZERO    = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_OVERLAP = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_FULL    = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_MISS    = 3'd4;

   localparam logic CMD_ADD  = 1'b0;
   localparam logic CMD_FIND = 1'b1;

   // Control part of the token that walks down the row of cells.
   typedef struct packed {
      logic valid;
      logic cmd;
      logic overlap;
      logic free_found;
      logic hit;
   } flags_type;

endpackage

`default_nettype wire

// File: sv/amr_if.sv
`default_nettype none

interface amr_req_if import amr_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 cmd;
   logic [WORD_BITS-1:0] address;
   logic [WORD_BITS-1:0] length;

   modport source (output valid, cmd, address, length, input ready);
   modport sink   (input valid, cmd, address, length, output ready);
endinterface

interface amr_rsp_if import amr_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic                       ok;
   logic [STATUS_BITS-1:0]     status;
   logic [SLOT_FIELD_BITS-1:0] slot;
   logic [WORD_BITS-1:0]       region_offset;

   modport source (output valid, ok, status, slot, region_offset, input ready);
   modport sink   (input valid, ok, status, slot, region_offset, output ready);
endinterface

`default_nettype wire

// File: sv/address_region_map.sv
`default_nettype none

// Region table as a row of NUM_REGIONS cells, one region per cell. A request word
// is taken into the first cell and moves one cell per cycle; each cell checks it
// against its own region, for overlap on an add and for containment on a find.
// After the last cell the result is formed and, on an accepted add, written into
// the lowest free cell. One word is handled at a time; the next request is taken
// only once the word has retired from the last cell. The response register lets
// the next request enter while a result still waits to be taken.
module address_region_map import amr_pkg::*; #(
   parameter int NUM_REGIONS  = NUM_REGIONS_DEFAULT,
   parameter int ADDRESS_BITS = ADDRESS_BITS_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   amr_req_if.sink   req_ch,
   amr_rsp_if.source rsp_ch
);

   localparam int SlotBits = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;

   flags_type               flags_chain  [NUM_REGIONS+1];
   logic [ADDRESS_BITS-1:0] addr_chain   [NUM_REGIONS+1];
   logic [ADDRESS_BITS-1:0] len_chain    [NUM_REGIONS+1];
   logic [SlotBits-1:0]     slot_chain   [NUM_REGIONS+1];
   logic [ADDRESS_BITS-1:0] offset_chain [NUM_REGIONS+1];

   logic                       busy_ff, busy_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_ok_ff;
   logic [STATUS_BITS-1:0]     rsp_status_ff;
   logic [SLOT_FIELD_BITS-1:0] rsp_slot_ff;
   logic [WORD_BITS-1:0]       rsp_offset_ff;

   logic                       accept;
   logic                       retire;
   logic                       advance;
   flags_type                  last;
   logic                       res_ok;
   logic [STATUS_BITS-1:0]     res_status;
   logic                       wr_en;

   assign req_ch.ready = !busy_ff;
   assign accept       = req_ch.valid && !busy_ff;

   assign last    = flags_chain[NUM_REGIONS];
   assign retire  = last.valid && (!rsp_valid_ff || rsp_ch.ready);
   assign advance = !(last.valid && !retire);

   assign flags_chain[0]  = '{valid: accept, cmd: req_ch.cmd, default: 1'b0};
   assign addr_chain[0]   = ADDRESS_BITS'(req_ch.address);
   assign len_chain[0]    = ADDRESS_BITS'(req_ch.length);
   assign slot_chain[0]   = '0;
   assign offset_chain[0] = '0;

   always_comb begin
      res_ok     = 1'b0;
      res_status = ST_MISS;
      wr_en      = 1'b0;
      if (last.cmd == CMD_ADD) begin
         priority if (len_chain[NUM_REGIONS] == '0) begin
            res_status = ST_ZERO;
         end else if (last.overlap) begin
            res_status = ST_OVERLAP;
         end else if (!last.free_found) begin
            res_status = ST_FULL;
         end else begin
            res_ok     = 1'b1;
            res_status = ST_OK;
            wr_en      = retire;
         end
      end else if (last.hit) begin
         res_ok     = 1'b1;
         res_status = ST_OK;
      end
   end

   for (genvar i = 0; i < NUM_REGIONS; i++) begin : g_cell
      amr_cell #(
         .ADDRESS_BITS (ADDRESS_BITS),
         .SLOT_BITS    (SlotBits),
         .CELL_INDEX   (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .flags_in   (flags_chain[i]),
         .addr_in    (addr_chain[i]),
         .len_in     (len_chain[i]),
         .slot_in    (slot_chain[i]),
         .offset_in  (offset_chain[i]),
         .wr_en      (wr_en),
         .wr_slot    (slot_chain[NUM_REGIONS]),
         .wr_base    (addr_chain[NUM_REGIONS]),
         .wr_len     (len_chain[NUM_REGIONS]),
         .flags_out  (flags_chain[i+1]),
         .addr_out   (addr_chain[i+1]),
         .len_out    (len_chain[i+1]),
         .slot_out   (slot_chain[i+1]),
         .offset_out (offset_chain[i+1])
      );
   end

   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (retire) begin
         busy_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (retire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (retire) begin
         rsp_ok_ff     <= res_ok;
         rsp_status_ff <= res_status;
         rsp_slot_ff   <= res_ok ? SLOT_FIELD_BITS'(slot_chain[NUM_REGIONS]) : '0;
         rsp_offset_ff <= (res_ok && last.cmd == CMD_FIND)
                          ? WORD_BITS'(offset_chain[NUM_REGIONS]) : '0;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.ok            = rsp_ok_ff;
   assign rsp_ch.status        = rsp_status_ff;
   assign rsp_ch.slot          = rsp_slot_ff;
   assign rsp_ch.region_offset = rsp_offset_ff;

endmodule

`default_nettype wire

// File: sv/amr_cell.sv
`default_nettype none

module amr_cell import amr_pkg::*; #(
   parameter int ADDRESS_BITS = ADDRESS_BITS_DEFAULT,
   parameter int SLOT_BITS    = 3,
   parameter int CELL_INDEX   = 0
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    advance,
   input  wire flags_type               flags_in,
   input  wire logic [ADDRESS_BITS-1:0] addr_in,
   input  wire logic [ADDRESS_BITS-1:0] len_in,
   input  wire logic [SLOT_BITS-1:0]    slot_in,
   input  wire logic [ADDRESS_BITS-1:0] offset_in,
   input  wire logic                    wr_en,
   input  wire logic [SLOT_BITS-1:0]    wr_slot,
   input  wire logic [ADDRESS_BITS-1:0] wr_base,
   input  wire logic [ADDRESS_BITS-1:0] wr_len,
   output flags_type                    flags_out,
   output logic [ADDRESS_BITS-1:0]      addr_out,
   output logic [ADDRESS_BITS-1:0]      len_out,
   output logic [SLOT_BITS-1:0]         slot_out,
   output logic [ADDRESS_BITS-1:0]      offset_out
);

   localparam logic [SLOT_BITS-1:0] MyIndex = SLOT_BITS'(CELL_INDEX);

   logic                    region_valid_ff;
   logic [ADDRESS_BITS-1:0] region_base_ff;
   logic [ADDRESS_BITS-1:0] region_len_ff;

   flags_type               flags_ff, flags_in_next;
   logic [ADDRESS_BITS-1:0] addr_ff, len_ff, offset_ff, offset_in_next;
   logic [SLOT_BITS-1:0]    slot_ff, slot_in_next;

   logic                    addr_ge;
   logic [ADDRESS_BITS-1:0] distance;
   logic [ADDRESS_BITS-1:0] room;
   logic                    overlaps;
   logic                    contained;

   assign addr_ge   = addr_in >= region_base_ff;
   assign distance  = addr_ge ? addr_in - region_base_ff : region_base_ff - addr_in;
   assign overlaps  = distance < (addr_ge ? region_len_ff : len_in);
   assign room      = region_len_ff - distance;
   assign contained = addr_ge && (distance < region_len_ff) && (len_in <= room);

   always_comb begin
      flags_in_next  = flags_in;
      slot_in_next   = slot_in;
      offset_in_next = offset_in;
      if (flags_in.valid) begin
         if (flags_in.cmd == CMD_ADD) begin
            if (region_valid_ff) begin
               if (overlaps) begin
                  flags_in_next.overlap = 1'b1;
               end
            end else if (!flags_in.free_found) begin
               flags_in_next.free_found = 1'b1;
               slot_in_next             = MyIndex;
            end
         end else if (!flags_in.hit && region_valid_ff && contained) begin
            flags_in_next.hit = 1'b1;
            slot_in_next      = MyIndex;
            offset_in_next    = distance;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         region_valid_ff <= 1'b0;
      end else if (wr_en && wr_slot == MyIndex) begin
         region_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && wr_slot == MyIndex) begin
         region_base_ff <= wr_base;
         region_len_ff  <= wr_len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else if (advance) begin
         flags_ff <= flags_in_next;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         addr_ff   <= addr_in;
         len_ff    <= len_in;
         slot_ff   <= slot_in_next;
         offset_ff <= offset_in_next;
      end
   end

   assign flags_out  = flags_ff;
   assign addr_out   = addr_ff;
   assign len_out    = len_ff;
   assign slot_out   = slot_ff;
   assign offset_out = offset_ff;

endmodule

`default_nettype wire

// File: sv/amr_checker.sv
`default_nettype none

module amr_checker import amr_pkg::*; (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_valid,
   input wire logic                       req_ready,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_ready,
   input wire logic                       rsp_ok,
   input wire logic [STATUS_BITS-1:0]     rsp_status,
   input wire logic [SLOT_FIELD_BITS-1:0] rsp_slot,
   input wire logic [WORD_BITS-1:0]       rsp_region_offset
);

   a_ok_matches_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_ok == (rsp_status == ST_OK)))
      else $error("ok flag disagrees with status");

   a_refusal_is_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ok) |-> (rsp_slot == '0 && rsp_region_offset == '0))
      else $error("refused or missed word carries slot or offset");

   a_status_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_OK || rsp_status == ST_ZERO ||
                     rsp_status == ST_OVERLAP || rsp_status == ST_FULL ||
                     rsp_status == ST_MISS))
      else $error("status code out of range");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while another is in the row");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_ok) &&
                                     $stable(rsp_status) && $stable(rsp_slot) &&
                                     $stable(rsp_region_offset)))
      else $error("stalled response word changed");

endmodule

bind address_region_map amr_checker u_amr_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_ok            (rsp_ch.ok),
   .rsp_status        (rsp_ch.status),
   .rsp_slot          (rsp_ch.slot),
   .rsp_region_offset (rsp_ch.region_offset)
);

`default_nettype wire

// File: test/tb_address_region_map.sv
`timescale 1ns / 100ps

module tb_address_region_map;
   import amr_pkg::*;

   localparam int MAP_SLOTS    = NUM_REGIONS_DEFAULT;
   localparam int TOTAL_ITEMS  = 850;
   localparam int LIMIT_CYCLES = 400000;
   localparam int DRAIN_CYCLES = MAP_SLOTS + 8;
   localparam int LONG_HOLD    = 300;
   localparam int MAX_PRINTS   = 30;

   typedef struct packed {
      logic                       ok;
      logic [STATUS_BITS-1:0]     status;
      logic [SLOT_FIELD_BITS-1:0] slot;
      logic [WORD_BITS-1:0]       region_offset;
   } rsp_word_type;

   typedef struct {
      logic                 cmd;
      logic [WORD_BITS-1:0] address;
      logic [WORD_BITS-1:0] length;
      bit                   typed;
      rsp_word_type         want;
   } req_word_type;

   typedef enum int {FLOW_FREE, FLOW_COIN, FLOW_SLOW} flow_mode_type;

   logic clock;
   logic reset;

   amr_req_if req_ch();
   amr_rsp_if rsp_ch();

   address_region_map dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   bit                   rgn_valid [MAP_SLOTS];
   logic [WORD_BITS-1:0] rgn_base  [MAP_SLOTS];
   logic [WORD_BITS-1:0] rgn_len   [MAP_SLOTS];

   req_word_type directed_rows[$];
   rsp_word_type exp_rsp_q[$];
   req_word_type cur_req;

   int  err_count     = 0;
   int  checked_count = 0;
   int  cycle_count   = 0;
   int  req_issued    = 0;
   int  req_accepted  = 0;
   int  n_add_ok      = 0;
   int  n_add_refused = 0;
   int  n_hit         = 0;
   int  n_miss        = 0;
   bit  offering      = 0;
   int  burst_left    = 1;
   int  gap_left      = 0;
   int  rsp_taken     = 0;
   int  hold_left     = 0;
   int  hold_mark     = 120;
   int  mode_left     = 0;
   int  phase         = 0;
   flow_mode_type flow_mode = FLOW_FREE;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Applies one command to the shadow region table and returns its response.
   function automatic rsp_word_type decode_region_cmd(input logic cmd,
                                                      input logic [WORD_BITS-1:0] a,
                                                      input logic [WORD_BITS-1:0] l);
      rsp_word_type         r;
      int                   free_slot;
      bit                   clash;
      logic [WORD_BITS-1:0] off;
      r = '{ok: 1'b0, status: ST_MISS, slot: '0, region_offset: '0};
      free_slot = -1;
      clash = 1'b0;
      if (cmd == CMD_ADD) begin
         if (l == '0) begin
            r.status = ST_ZERO;
         end else begin
            for (int i = 0; i < MAP_SLOTS; i++) begin
               if (rgn_valid[i]) begin
                  if (a >= rgn_base[i] ? (a - rgn_base[i]) < rgn_len[i]
                                       : (rgn_base[i] - a) < l)
                     clash = 1'b1;
               end else if (free_slot < 0) begin
                  free_slot = i;
               end
            end
            if (clash) begin
               r.status = ST_OVERLAP;
            end else if (free_slot < 0) begin
               r.status = ST_FULL;
            end else begin
               rgn_valid[free_slot] = 1'b1;
               rgn_base[free_slot]  = a;
               rgn_len[free_slot]   = l;
               r.ok     = 1'b1;
               r.status = ST_OK;
               r.slot   = SLOT_FIELD_BITS'(free_slot);
            end
         end
      end else begin
         for (int i = 0; i < MAP_SLOTS && !r.ok; i++) begin
            if (rgn_valid[i] && a >= rgn_base[i]) begin
               off = a - rgn_base[i];
               if (off < rgn_len[i] && l <= rgn_len[i] - off) begin
                  r.ok            = 1'b1;
                  r.status        = ST_OK;
                  r.slot          = SLOT_FIELD_BITS'(i);
                  r.region_offset = off;
               end
            end
         end
      end
      return r;
   endfunction

   task automatic add_row(input logic cmd, input logic [WORD_BITS-1:0] a,
                          input logic [WORD_BITS-1:0] l, input bit typed,
                          input logic ok = 1'b0,
                          input logic [STATUS_BITS-1:0] st = ST_MISS,
                          input logic [SLOT_FIELD_BITS-1:0] slot = '0,
                          input logic [WORD_BITS-1:0] off = '0);
      directed_rows.push_back('{cmd: cmd, address: a, length: l, typed: typed,
                                want: '{ok: ok, status: st, slot: slot,
                                        region_offset: off}});
   endtask

   task automatic report_mismatch(input string what, input logic [WORD_BITS-1:0] got,
                                  input logic [WORD_BITS-1:0] want);
      if (err_count < MAX_PRINTS)
         $display("Mismatch on response %0d, %s: got %h, expected %h",
                  checked_count, what, got, want);
      err_count++;
   endtask

   always @(posedge clock) begin : req_drive
      rsp_word_type         pred;
      int                   sel;
      int                   s;
      logic [WORD_BITS-1:0] b;
      logic [WORD_BITS-1:0] l;
      logic [WORD_BITS-1:0] off;
      logic [WORD_BITS:0]   room;
      req_word_type         nxt;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            pred = decode_region_cmd(cur_req.cmd, cur_req.address, cur_req.length);
            exp_rsp_q.push_back(cur_req.typed ? cur_req.want : pred);
            if (cur_req.cmd == CMD_ADD) begin
               if (pred.ok) n_add_ok++;
               else n_add_refused++;
            end else begin
               if (pred.ok) n_hit++;
               else n_miss++;
            end
            req_accepted++;
            offering = 1'b0;
         end
         if (!offering) begin
            if (gap_left > 0) begin
               gap_left--;
               req_ch.valid <= 1'b0;
            end else if (req_issued == TOTAL_ITEMS) begin
               req_ch.valid <= 1'b0;
            end else begin
               if (directed_rows.size() > 0) begin
                  nxt = directed_rows.pop_front();
               end else begin
                  nxt.typed = 1'b0;
                  nxt.want  = '0;
                  sel = $urandom_range(0, 99);
                  s   = $urandom_range(0, MAP_SLOTS - 1);
                  if (rgn_valid[s]) begin
                     b = rgn_base[s];
                     l = rgn_len[s];
                  end else begin
                     b = $urandom;
                     l = $urandom_range(1, 4096);
                  end
                  off = $urandom % l;
                  if (sel < 70) begin
                     nxt.cmd = CMD_FIND;
                     case ($urandom_range(0, 6))
                        0: begin
                           room = {1'b0, l} - {1'b0, off} + 1'b1;
                           nxt.address = b + off;
                           nxt.length  = WORD_BITS'({1'b0, $urandom} % room);
                        end
                        1: begin
                           nxt.address = b;
                           nxt.length  = l;
                        end
                        2: begin
                           nxt.address = b;
                           nxt.length  = l + 1'b1;
                        end
                        3: begin
                           nxt.address = b + off;
                           nxt.length  = l - off + 1'b1;
                        end
                        4: begin
                           nxt.address = b - 1'b1;
                           nxt.length  = $urandom_range(0, 4);
                        end
                        5: begin
                           nxt.address = b + l - 1'b1;
                           nxt.length  = $urandom_range(0, 2);
                        end
                        default: begin
                           nxt.address = b + l;
                           nxt.length  = '0;
                        end
                     endcase
                  end else if (sel < 90) begin
                     nxt.cmd = CMD_ADD;
                     case ($urandom_range(0, 3))
                        0: begin
                           nxt.address = $urandom;
                           nxt.length  = '0;
                        end
                        1: begin
                           nxt.address = b + off;
                           nxt.length  = $urandom_range(1, 1000);
                        end
                        2: begin
                           nxt.address = b + l;
                           nxt.length  = $urandom_range(1, 64);
                        end
                        default: begin
                           nxt.address = $urandom;
                           nxt.length  = $urandom;
                        end
                     endcase
                  end else begin
                     nxt.cmd     = 1'($urandom_range(0, 1));
                     nxt.address = $urandom;
                     nxt.length  = ($urandom_range(0, 1) == 0) ? $urandom
                                                               : $urandom_range(0, 16);
                  end
               end
               cur_req = nxt;
               req_ch.valid   <= 1'b1;
               req_ch.cmd     <= nxt.cmd;
               req_ch.address <= nxt.address;
               req_ch.length  <= nxt.length;
               offering = 1'b1;
               req_issued++;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 30);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 14);
               end
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_drive
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) rsp_taken++;
         if (hold_left == 0 && rsp_taken >= hold_mark) begin
            hold_left = LONG_HOLD;
            hold_mark += 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               flow_mode = flow_mode_type'($urandom_range(0, 2));
               mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            phase++;
            case (flow_mode)
               FLOW_FREE: rsp_ch.ready <= 1'b1;
               FLOW_COIN: rsp_ch.ready <= 1'($urandom_range(0, 1));
               default:   rsp_ch.ready <= (phase % 5 == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      rsp_word_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (exp_rsp_q.size() == 0) begin
            report_mismatch("response with nothing outstanding",
                            WORD_BITS'(rsp_ch.status), '0);
         end else begin
            want = exp_rsp_q.pop_front();
            if (rsp_ch.ok !== want.ok)
               report_mismatch("ok", WORD_BITS'(rsp_ch.ok), WORD_BITS'(want.ok));
            if (rsp_ch.status !== want.status)
               report_mismatch("status", WORD_BITS'(rsp_ch.status),
                               WORD_BITS'(want.status));
            if (rsp_ch.slot !== want.slot)
               report_mismatch("slot", WORD_BITS'(rsp_ch.slot), WORD_BITS'(want.slot));
            if (rsp_ch.region_offset !== want.region_offset)
               report_mismatch("region_offset", rsp_ch.region_offset, want.region_offset);
         end
         checked_count++;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Timed out with %0d requests accepted and %0d responses outstanding.",
                  req_accepted, exp_rsp_q.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin : main
      logic [WORD_BITS-1:0] wbase[4];
      logic [WORD_BITS-1:0] wlen[4];
      clock          = 1'b0;
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.cmd     = CMD_ADD;
      req_ch.address = '0;
      req_ch.length  = '0;
      rsp_ch.ready   = 1'b0;

      add_row(CMD_FIND, 32'h0, 32'h0, 1'b1);
      add_row(CMD_FIND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      add_row(CMD_ADD, 32'h1000, 32'h0, 1'b1, 1'b0, ST_ZERO);
      add_row(CMD_ADD, 32'h0, 32'h1, 1'b1, 1'b1, ST_OK, 3'd0);
      add_row(CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, ST_OK, 3'd1);
      add_row(CMD_ADD, 32'hFFFF_FFFE, 32'h2, 1'b1, 1'b0, ST_OVERLAP);
      add_row(CMD_ADD, 32'h0, 32'hFFFF_FFFF, 1'b1, 1'b0, ST_OVERLAP);
      // These two touch neighbors on either side without sharing an address.
      add_row(CMD_ADD, 32'h1, 32'h10, 1'b1, 1'b1, ST_OK, 3'd2);
      add_row(CMD_ADD, 32'hFFFF_FFF0, 32'hF, 1'b1, 1'b1, ST_OK, 3'd3);
      add_row(CMD_FIND, 32'h0, 32'h1, 1'b1, 1'b1, ST_OK, 3'd0, 32'h0);
      add_row(CMD_FIND, 32'h0, 32'h2, 1'b1);
      add_row(CMD_FIND, 32'h10, 32'h0, 1'b1, 1'b1, ST_OK, 3'd2, 32'hF);
      add_row(CMD_FIND, 32'h11, 32'h0, 1'b1);
      add_row(CMD_FIND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, ST_OK, 3'd1, 32'h0);
      add_row(CMD_FIND, 32'hFFFF_FFFF, 32'h0, 1'b1, 1'b1, ST_OK, 3'd1, 32'h0);
      for (int k = 0; k < 4; k++) begin
         wbase[k] = (32'(k + 4) << 28) + $urandom_range(0, 32'h0800_0000);
         wlen[k]  = $urandom_range(1, 32'h0800_0000);
         add_row(CMD_ADD, wbase[k], wlen[k], 1'b0);
      end
      // With every slot taken, zero length and overlap still win over a full table.
      add_row(CMD_ADD, 32'h2000_0000, 32'h100, 1'b1, 1'b0, ST_FULL);
      add_row(CMD_ADD, 32'hFFFF_FFF8, 32'h0, 1'b1, 1'b0, ST_ZERO);
      add_row(CMD_ADD, 32'h0, 32'hFFFF_FFFF, 1'b1, 1'b0, ST_OVERLAP);
      add_row(CMD_FIND, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1);
      add_row(CMD_FIND, wbase[0] + wlen[0] - 1'b1, 32'h1, 1'b0);
      add_row(CMD_FIND, wbase[0], wlen[0], 1'b0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (!(req_accepted == TOTAL_ITEMS && exp_rsp_q.size() == 0))
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests: %0d adds stored, %0d adds refused, %0d finds hit, %0d missed.",
               req_accepted, n_add_ok, n_add_refused, n_hit, n_miss);
      $display("Checked %0d responses, with two long response stalls; %0d mismatches.",
               checked_count, err_count);
      if (err_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
